// File: rtl/pft_pkg.sv
`default_nettype none

package pft_pkg;

  localparam int unsigned TicksW  = 10;
  localparam int unsigned MicroW  = 32;
  localparam int unsigned SecondW = 16;
  localparam int unsigned FrameW  = 16;

  // Microseconds in one second, the step of the running seconds base.
  localparam logic [MicroW-1:0] UsPerSecond = 32'd1000000;

  // Divide value after reset.
  localparam logic [TicksW-1:0] TicksReset = 10'd100;

  typedef struct packed {
    logic              event_valid;
    logic              event_is_end;
    logic [FrameW-1:0] frame_number;
    logic [MicroW-1:0] timestamp_us;
    logic              led_level;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/pps_frame_timestamper.sv
`default_nettype none

// PPS frame timestamper. Every input transaction is one tick of the sampling
// clock carrying the sampled pulse-per-second and flash levels, and every
// input transaction produces exactly one registered output transaction.
// A prescaler divides ticks into microseconds (ticks_per_microsecond, reset
// 100, a value of 0 acts like 1); a rising PPS edge clears the prescaler and
// the microsecond count and advances the seconds count. A rising flash edge
// reports a frame start, a falling one a frame end, stamped with
// seconds * 1000000 + microseconds modulo 2^32. The first tick after reset
// only samples the two levels. The block accepts one transaction per clock
// cycle while in_stall_o is low. The counter update and the 32-bit timestamp
// add are combinational and sit between the counter state and the output
// register. A two-entry output stage (output register plus skid register)
// lets an input be taken while a result waits, so in_stall_o is registered.
// Write ticks_per_microsecond only while idle.
module pps_frame_timestamper (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Configuration write channel.
  input  wire logic                      cfg_valid_i,
  output      logic                      cfg_ready_o,
  input  wire logic [pft_pkg::TicksW-1:0] ticks_per_microsecond_i,
  // Input channel.
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire logic                      pps_level_i,
  input  wire logic                      flash_level_i,
  // Output channel.
  output      logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  output      logic                      event_valid_o,
  output      logic                      event_is_end_o,
  output      logic [pft_pkg::FrameW-1:0] frame_number_o,
  output      logic [pft_pkg::MicroW-1:0] timestamp_us_o,
  output      logic                      led_level_o
);
  import pft_pkg::*;

  // Counter state.
  logic [TicksW-1:0]  ticks_q;
  logic               primed_q, primed_d;
  logic               last_pps_q;
  logic               last_flash_q;
  logic [TicksW-1:0]  prescale_q, prescale_d;
  logic [MicroW-1:0]  micro_q, micro_d;
  logic [SecondW-1:0] second_q, second_d;
  // Running value of second_q * 1000000 modulo 2^32, kept so that no
  // multiplier is needed for the timestamp.
  logic [MicroW-1:0]  sec_base_q, sec_base_d;
  logic [FrameW-1:0]  frame_q, frame_d;

  // Output stage.
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_res_q, out_res_d;
  result_t skid_res_q, skid_res_d;
  result_t new_res;

  logic              accept;
  logic              out_free;
  logic              pps_rise;
  logic              flash_edge;
  logic [TicksW:0]   prescale_inc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign pps_rise     = pps_level_i && !last_pps_q;
  assign flash_edge   = flash_level_i != last_flash_q;
  assign prescale_inc = {1'b0, prescale_q} + {{TicksW{1'b0}}, 1'b1};

  // Counter update and result formation for one tick.
  always_comb begin
    prescale_d = prescale_q;
    micro_d    = micro_q;
    second_d   = second_q;
    sec_base_d = sec_base_q;
    frame_d    = frame_q;
    primed_d   = 1'b1;

    new_res              = '0;
    new_res.led_level    = pps_level_i;

    if (primed_q) begin
      if (pps_rise) begin
        prescale_d = '0;
        micro_d    = '0;
        second_d   = second_q + {{(SecondW-1){1'b0}}, 1'b1};
        // The base returns to zero together with the seconds count.
        sec_base_d = (&second_q) ? '0 : sec_base_q + UsPerSecond;
      end else if (prescale_inc >= {1'b0, ticks_q}) begin
        prescale_d = '0;
        micro_d    = micro_q + {{(MicroW-1){1'b0}}, 1'b1};
      end else begin
        prescale_d = prescale_inc[TicksW-1:0];
      end

      if (flash_edge) begin
        new_res.event_valid  = 1'b1;
        new_res.timestamp_us = sec_base_d + micro_d;
        if (flash_level_i) begin
          new_res.frame_number = frame_q;
          frame_d              = frame_q + {{(FrameW-1){1'b0}}, 1'b1};
        end else begin
          new_res.event_is_end = 1'b1;
          // A falling edge before any frame start reports frame 0.
          new_res.frame_number = (frame_q == '0) ? '0
                                 : frame_q - {{(FrameW-1){1'b0}}, 1'b1};
        end
      end
    end
  end

  // Output register with a skid register behind it.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_res_d    = out_res_q;
    skid_valid_d = skid_valid_q;
    skid_res_d   = skid_res_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_res_d    = skid_res_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = accept;
        out_res_d   = new_res;
      end
    end else if (accept) begin
      skid_valid_d = 1'b1;
      skid_res_d   = new_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q      <= TicksReset;
      primed_q     <= 1'b0;
      last_pps_q   <= 1'b0;
      last_flash_q <= 1'b0;
      prescale_q   <= '0;
      micro_q      <= '0;
      second_q     <= '0;
      sec_base_q   <= '0;
      frame_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        ticks_q <= ticks_per_microsecond_i;
      end
      if (accept) begin
        primed_q     <= primed_d;
        last_pps_q   <= pps_level_i;
        last_flash_q <= flash_level_i;
        prescale_q   <= prescale_d;
        micro_q      <= micro_d;
        second_q     <= second_d;
        sec_base_q   <= sec_base_d;
        frame_q      <= frame_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

  assign out_valid_o    = out_valid_q;
  assign event_valid_o  = out_res_q.event_valid;
  assign event_is_end_o = out_res_q.event_is_end;
  assign frame_number_o = out_res_q.frame_number;
  assign timestamp_us_o = out_res_q.timestamp_us;
  assign led_level_o    = out_res_q.led_level;

endmodule

`default_nettype wire

// File: rtl/pft_checker.sv
`default_nettype none

module pft_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic                       event_valid_o,
  input wire logic                       event_is_end_o,
  input wire logic [pft_pkg::FrameW-1:0] frame_number_o,
  input wire logic [pft_pkg::MicroW-1:0] timestamp_us_o
);
  import pft_pkg::*;

  // A held result keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(timestamp_us_o)
      && $stable(frame_number_o) && $stable(event_valid_o))
    else $error("stalled result changed");

  // The input side only stalls while a result sits in the output register.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // Input stall starts only after the output was held.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without output backpressure");

  // Results without an event carry zero payload.
  a_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !event_valid_o |-> !event_is_end_o
      && (frame_number_o == '0) && (timestamp_us_o == '0))
    else $error("payload set without event");

endmodule

bind pps_frame_timestamper pft_checker u_pft_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .event_valid_o  (event_valid_o),
  .event_is_end_o (event_is_end_o),
  .frame_number_o (frame_number_o),
  .timestamp_us_o (timestamp_us_o)
);

`default_nettype wire
